// ===== rtl/fms_pkg.sv =====
// Shared types, mode and status codes and reset values for the flight mode supervisor.
package fms_pkg;

  localparam int unsigned PULSE_W = 12;
  localparam int unsigned SATS_W  = 6;
  localparam int unsigned CONF_W  = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned STAT_W  = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 48;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_AUX_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUX_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUX_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SW_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SATS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_THR = 3'd5;

  // Flight modes
  localparam logic [MODE_W-1:0] MODE_MANUAL    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STABILIZE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALTHOLD   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POSHOLD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RETURN    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HEADLESS  = 3'd5;

  // Result status
  localparam logic [STAT_W-1:0] ST_NONE       = 3'd0;
  localparam logic [STAT_W-1:0] ST_CHANGED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_GPS     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_HOME    = 3'd3;
  localparam logic [STAT_W-1:0] ST_TO_ALTHOLD = 3'd4;
  localparam logic [STAT_W-1:0] ST_TO_STAB    = 3'd5;

  // Request kinds carried on tuser
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_SWITCH = 1'b1;

  // Configuration reset values
  localparam logic [PULSE_W-1:0] AUX_LOW_RST  = 12'd1300;
  localparam logic [PULSE_W-1:0] AUX_MID_RST  = 12'd1500;
  localparam logic [PULSE_W-1:0] AUX_HIGH_RST = 12'd1700;
  localparam logic [PULSE_W-1:0] SW_ON_RST    = 12'd1700;
  localparam logic [SATS_W-1:0]  MIN_SATS_RST = 6'd6;
  localparam logic [CONF_W-1:0]  CONF_THR_RST = 10'd300;

  typedef struct packed {
    logic [PULSE_W-1:0] aux_low;
    logic [PULSE_W-1:0] aux_mid;
    logic [PULSE_W-1:0] aux_high;
    logic [PULSE_W-1:0] switch_on;
    logic [SATS_W-1:0]  min_sats;
    logic [CONF_W-1:0]  conf_thr;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [PULSE_W-1:0] aux1_pulse;
    logic [PULSE_W-1:0] aux2_pulse;
    logic [PULSE_W-1:0] aux3_pulse;
    logic               gps_fix;
    logic               gps_healthy;
    logic [SATS_W-1:0]  gps_satellites;
    logic               synth_valid;
    logic [CONF_W-1:0]  synth_confidence;
    logic [TIME_W-1:0]  time_ms;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MODE_W-1:0] last_mode;
    logic              home_valid;
    logic              home_capture;
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] change_stamp;
  } result_t;

endpackage

// ===== rtl/flight_mode_supervisor.sv =====
// A beat accepted into the input register is decided combinationally there and moves
// into the result register, which drives m_tdata, once that register is free or being emptied.
// Throughput: one beat per cycle while the sink keeps m_tready high; the input register
// and the result register let a new beat in while a finished result waits for m_tready.
// The decision for each beat reads the mode state left by the previous beat.
// Reset (rst, synchronous): both stages empty, mode and last mode stabilize,
// no home, change stamp zero, thresholds back to their defaults.
module flight_mode_supervisor
  import fms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input beats
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // aux1_pulse[11:0], aux2_pulse[23:12], aux3_pulse[35:24], gps_fix[36],
  // gps_healthy[37], gps_satellites[43:38], synth_valid[44],
  // synth_confidence[54:45], time_ms[86:55], zero pad[87]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic                  s_tuser,
  // Result beats
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // mode[2:0], last_mode[5:3], home_valid[6], home_capture[7], status[10:8],
  // change_stamp[42:11], zero pad[47:43]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t out_reg;
  logic    out_valid;

  fms_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held beat into the result register when that register is
  // free or being emptied this cycle; the state commits at the same edge.
  assign advance  = item_valid && (!out_valid || m_tready);
  assign s_tready = !item_valid || advance;

  // Input register: hold the accepted beat until it can be decided.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.req_type         <= s_tuser;
      item.aux1_pulse       <= s_tdata[11:0];
      item.aux2_pulse       <= s_tdata[23:12];
      item.aux3_pulse       <= s_tdata[35:24];
      item.gps_fix          <= s_tdata[36];
      item.gps_healthy      <= s_tdata[37];
      item.gps_satellites   <= s_tdata[43:38];
      item.synth_valid      <= s_tdata[44];
      item.synth_confidence <= s_tdata[54:45];
      item.time_ms          <= s_tdata[86:55];
    end
  end

  fms_mode_core u_mode_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register: hold until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_reg.change_stamp, out_reg.status, out_reg.home_capture,
                     out_reg.home_valid, out_reg.last_mode, out_reg.mode};

  // A home capture always shows home as latched
  a_capture_home: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_reg.home_capture || out_reg.home_valid))
    else $error("home capture without home valid");

  // A reported change leaves the new mode different from the recorded one
  a_change_differs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.status == ST_CHANGED) |-> (out_reg.mode != out_reg.last_mode))
    else $error("change reported with equal modes");

  // A fallback to altitude hold lands in altitude hold
  a_fallback_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.status == ST_TO_ALTHOLD) |-> (out_reg.mode == MODE_ALTHOLD))
    else $error("fallback status without altitude hold");

  // Home stays latched once seen, until reset
  a_home_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(advance) && $past(result.home_valid)) |-> out_reg.home_valid)
    else $error("home latch lost");

  // A waiting result only changes when a beat advances into the register
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(out_valid) && !$past(advance)) |-> $stable(out_reg))
    else $error("result register changed without a beat");

endmodule

// ===== rtl/fms_cfg_regs.sv =====
// Configuration register file for the flight mode supervisor.
module fms_cfg_regs
  import fms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aux_low   <= AUX_LOW_RST;
      cfg.aux_mid   <= AUX_MID_RST;
      cfg.aux_high  <= AUX_HIGH_RST;
      cfg.switch_on <= SW_ON_RST;
      cfg.min_sats  <= MIN_SATS_RST;
      cfg.conf_thr  <= CONF_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AUX_LOW:  cfg.aux_low   <= cfg_wdata;
        REG_AUX_MID:  cfg.aux_mid   <= cfg_wdata;
        REG_AUX_HIGH: cfg.aux_high  <= cfg_wdata;
        REG_SW_ON:    cfg.switch_on <= cfg_wdata;
        REG_MIN_SATS: cfg.min_sats  <= cfg_wdata[SATS_W-1:0];
        REG_CONF_THR: cfg.conf_thr  <= cfg_wdata[CONF_W-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

endmodule

// ===== rtl/fms_mode_core.sv =====
// Mode decision logic and supervisor state registers.
module fms_mode_core
  import fms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [MODE_W-1:0] mode_reg, mode_next;
  logic [MODE_W-1:0] prior_mode_reg, prior_mode_next;
  logic              home_flag, home_next;
  logic [TIME_W-1:0] stamp_reg, stamp_next;

  logic              sats_ok;
  logic              synth_ok;
  logic              gps_ok;
  logic              capture;
  logic [MODE_W-1:0] want;
  logic [STAT_W-1:0] status;

  assign sats_ok  = item.gps_satellites >= cfg.min_sats;
  assign synth_ok = item.synth_valid && (item.synth_confidence > cfg.conf_thr);
  assign gps_ok   = (item.gps_healthy && item.gps_fix && sats_ok) || synth_ok;

  // Requested mode from the aux channels; AUX3 wins over AUX2
  always_comb begin
    if (item.aux1_pulse < cfg.aux_low)       want = MODE_MANUAL;
    else if (item.aux1_pulse < cfg.aux_mid)  want = MODE_STABILIZE;
    else if (item.aux1_pulse < cfg.aux_high) want = MODE_ALTHOLD;
    else                                     want = MODE_POSHOLD;
    if (item.aux2_pulse > cfg.switch_on) want = MODE_RETURN;
    if (item.aux3_pulse > cfg.switch_on) want = MODE_HEADLESS;
  end

  always_comb begin
    mode_next       = mode_reg;
    prior_mode_next = prior_mode_reg;
    home_next       = home_flag;
    stamp_next      = stamp_reg;
    status          = ST_NONE;
    capture         = 1'b0;
    if (item.req_type == REQ_UPDATE) begin
      capture   = !home_flag && item.gps_fix && sats_ok;
      home_next = home_flag || capture;
      if (mode_reg == MODE_POSHOLD) begin
        if (!item.gps_fix && !synth_ok) begin
          mode_next = MODE_ALTHOLD;
          status    = ST_TO_ALTHOLD;
        end
      end else if (mode_reg == MODE_RETURN) begin
        if (!(home_next && item.gps_fix)) begin
          mode_next = MODE_STABILIZE;
          status    = ST_TO_STAB;
        end
      end
    end else begin
      if ((want == MODE_POSHOLD || want == MODE_RETURN) && !gps_ok) begin
        status = ST_NO_GPS;
      end else if (want == MODE_RETURN && !home_flag) begin
        status = ST_NO_HOME;
      end else if (want != mode_reg) begin
        prior_mode_next = mode_reg;
        mode_next       = want;
        stamp_next      = item.time_ms;
        status          = ST_CHANGED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_STABILIZE;
      prior_mode_reg <= MODE_STABILIZE;
      home_flag      <= 1'b0;
      stamp_reg      <= '0;
    end else if (advance) begin
      mode_reg       <= mode_next;
      prior_mode_reg <= prior_mode_next;
      home_flag      <= home_next;
      stamp_reg      <= stamp_next;
    end
  end

  assign result.mode         = mode_next;
  assign result.last_mode    = prior_mode_next;
  assign result.home_valid   = home_next;
  assign result.home_capture = capture;
  assign result.status       = status;
  assign result.change_stamp = stamp_next;

endmodule

// ===== dv/fms_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the flight mode supervisor: predicts every result beat and checks it.
module fms_checker
  import fms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // aux1_pulse, aux2_pulse, aux3_pulse, gps_fix, gps_healthy, gps_satellites,
  // synth_valid, synth_confidence, time_ms, zero pad (lowest bit first)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // mode, last_mode, home_valid, home_capture, status, change_stamp, zero pad
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    failures,
  output int                    outstanding,
  output int                    checked,
  output logic [5:0]            status_seen
);

  cfg_t              thresholds;
  logic [MODE_W-1:0] flight_mode;
  logic [MODE_W-1:0] prior_mode;
  logic              home_latched;
  logic [TIME_W-1:0] change_time;
  result_t           reports_due[$];
  int                fail_count;
  int                check_count;
  logic [5:0]        seen;

  function automatic item_t unpack_beat(input logic [IN_DATA_W-1:0] d, input logic kind);
    item_t it;
    it.req_type         = kind;
    it.aux1_pulse       = d[11:0];
    it.aux2_pulse       = d[23:12];
    it.aux3_pulse       = d[35:24];
    it.gps_fix          = d[36];
    it.gps_healthy      = d[37];
    it.gps_satellites   = d[43:38];
    it.synth_valid      = d[44];
    it.synth_confidence = d[54:45];
    it.time_ms          = d[86:55];
    return it;
  endfunction

  // Advance the supervisor state by one beat and return the report it produces
  function automatic result_t step_supervisor(input item_t it);
    result_t           r;
    logic [MODE_W-1:0] wanted;
    logic              synth_ok;
    logic              gps_ok;
    r.status       = ST_NONE;
    r.home_capture = 1'b0;
    synth_ok = it.synth_valid && (it.synth_confidence > thresholds.conf_thr);
    if (it.req_type == REQ_UPDATE) begin
      if (!home_latched && it.gps_fix && it.gps_satellites >= thresholds.min_sats) begin
        home_latched   = 1'b1;
        r.home_capture = 1'b1;
      end
      if (flight_mode == MODE_POSHOLD) begin
        if (!it.gps_fix && !synth_ok) begin
          flight_mode = MODE_ALTHOLD;
          r.status    = ST_TO_ALTHOLD;
        end
      end else if (flight_mode == MODE_RETURN) begin
        if (!(home_latched && it.gps_fix)) begin
          flight_mode = MODE_STABILIZE;
          r.status    = ST_TO_STAB;
        end
      end
    end else begin
      if (it.aux1_pulse < thresholds.aux_low) wanted = MODE_MANUAL;
      else if (it.aux1_pulse < thresholds.aux_mid) wanted = MODE_STABILIZE;
      else if (it.aux1_pulse < thresholds.aux_high) wanted = MODE_ALTHOLD;
      else wanted = MODE_POSHOLD;
      if (it.aux2_pulse > thresholds.switch_on) wanted = MODE_RETURN;
      if (it.aux3_pulse > thresholds.switch_on) wanted = MODE_HEADLESS;
      gps_ok = (it.gps_healthy && it.gps_fix && it.gps_satellites >= thresholds.min_sats)
               || synth_ok;
      if ((wanted == MODE_POSHOLD || wanted == MODE_RETURN) && !gps_ok) begin
        r.status = ST_NO_GPS;
      end else if (wanted == MODE_RETURN && !home_latched) begin
        r.status = ST_NO_HOME;
      end else if (wanted != flight_mode) begin
        prior_mode  = flight_mode;
        flight_mode = wanted;
        change_time = it.time_ms;
        r.status    = ST_CHANGED;
      end
    end
    r.mode         = flight_mode;
    r.last_mode    = prior_mode;
    r.home_valid   = home_latched;
    r.change_stamp = change_time;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      thresholds   = '{aux_low: AUX_LOW_RST, aux_mid: AUX_MID_RST, aux_high: AUX_HIGH_RST,
                       switch_on: SW_ON_RST, min_sats: MIN_SATS_RST, conf_thr: CONF_THR_RST};
      flight_mode  = MODE_STABILIZE;
      prior_mode   = MODE_STABILIZE;
      home_latched = 1'b0;
      change_time  = '0;
      reports_due.delete();
      fail_count   = 0;
      check_count  = 0;
      seen         = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_AUX_LOW:  thresholds.aux_low   = cfg_wdata;
          REG_AUX_MID:  thresholds.aux_mid   = cfg_wdata;
          REG_AUX_HIGH: thresholds.aux_high  = cfg_wdata;
          REG_SW_ON:    thresholds.switch_on = cfg_wdata;
          REG_MIN_SATS: thresholds.min_sats  = cfg_wdata[SATS_W-1:0];
          REG_CONF_THR: thresholds.conf_thr  = cfg_wdata[CONF_W-1:0];
          default: ;
        endcase
      end
      // Retire the result first: a beat taken at this edge cannot be out yet
      if (m_tvalid && m_tready) begin
        got.mode         = m_tdata[2:0];
        got.last_mode    = m_tdata[5:3];
        got.home_valid   = m_tdata[6];
        got.home_capture = m_tdata[7];
        got.status       = m_tdata[10:8];
        got.change_stamp = m_tdata[42:11];
        if (reports_due.size() == 0) begin
          if (fail_count < 10)
            $display("UNEXPECTED result beat with nothing outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          check_count++;
          if (got.status < 6) seen[got.status] = 1'b1;
          if (got.mode !== want.mode || got.last_mode !== want.last_mode ||
              got.home_valid !== want.home_valid ||
              got.home_capture !== want.home_capture ||
              got.status !== want.status || got.change_stamp !== want.change_stamp) begin
            if (fail_count < 10)
              $display({"MISMATCH result %0d (exp/act): mode %0d/%0d last %0d/%0d ",
                        "home %0b/%0b capture %0b/%0b status %0d/%0d stamp %h/%h"},
                       check_count, want.mode, got.mode, want.last_mode, got.last_mode,
                       want.home_valid, got.home_valid, want.home_capture,
                       got.home_capture, want.status, got.status,
                       want.change_stamp, got.change_stamp);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        reports_due.push_back(step_supervisor(unpack_beat(s_tdata, s_tuser)));
    end
    failures    <= fail_count;
    outstanding <= reports_due.size();
    checked     <= check_count;
    status_seen <= seen;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the flight mode supervisor regression: clock, reset, stimulus and verdict.
module tb_top;
  import fms_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_BLOCKS   = 6;
  localparam int BEATS_PER_BLOCK = 155;
  // Indexes beyond the register file; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int         failures;
  int         outstanding;
  int         checked;
  logic [5:0] status_seen;

  int   send_idle_pct   = 10;
  int   recv_idle_pct   = 62;
  int   hold_request    = 0;
  int   hold_left       = 0;
  int   cycle_count     = 0;
  int   beats_sent      = 0;
  int   settings_loaded = 0;
  cfg_t cfg_now;

  flight_mode_supervisor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  fms_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .failures   (failures),
    .outstanding(outstanding),
    .checked    (checked),
    .status_seen(status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up well past the slowest legal run; every beat yields exactly one result,
  // so this covers all sender gaps, receiver stalls and the long hold-off together
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("flight_mode_supervisor regression: fail");
    $finish;
  end

  // Result side: stall at the current rate, or hold off completely while a
  // requested hold-off is still counting down
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_beat(input item_t it);
    return {1'b0, it.time_ms, it.synth_confidence, it.synth_valid, it.gps_satellites,
            it.gps_healthy, it.gps_fix, it.aux3_pulse, it.aux2_pulse, it.aux1_pulse};
  endfunction

  function automatic item_t mk_beat(input logic kind, input int a1, input int a2,
                                    input int a3, input int fix, input int healthy,
                                    input int sats, input int sv, input int conf,
                                    input logic [TIME_W-1:0] stamp);
    item_t it;
    it.req_type         = kind;
    it.aux1_pulse       = a1[PULSE_W-1:0];
    it.aux2_pulse       = a2[PULSE_W-1:0];
    it.aux3_pulse       = a3[PULSE_W-1:0];
    it.gps_fix          = (fix != 0);
    it.gps_healthy      = (healthy != 0);
    it.gps_satellites   = sats[SATS_W-1:0];
    it.synth_valid      = (sv != 0);
    it.synth_confidence = conf[CONF_W-1:0];
    it.time_ms          = stamp;
    return it;
  endfunction

  // Pick a value a few steps either side of a threshold, kept within the field
  function automatic int near_value(input int centre, input int top_val);
    int v;
    v = centre + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > top_val) v = top_val;
    return v;
  endfunction

  // Random beat aimed at the current thresholds so that every mode decision
  // and every status is reached; the switch channels are mostly off
  function automatic item_t random_beat();
    item_t it;
    it.req_type = ($urandom_range(1) != 0) ? REQ_SWITCH : REQ_UPDATE;
    case ($urandom_range(4))
      0:       it.aux1_pulse = PULSE_W'($urandom_range(4095));
      1:       it.aux1_pulse = PULSE_W'(near_value(int'(cfg_now.aux_low), 4095));
      2:       it.aux1_pulse = PULSE_W'(near_value(int'(cfg_now.aux_mid), 4095));
      3:       it.aux1_pulse = PULSE_W'(near_value(int'(cfg_now.aux_high), 4095));
      default: it.aux1_pulse = PULSE_W'($urandom_range(2100, 900));
    endcase
    if ($urandom_range(9) == 0) it.aux2_pulse = PULSE_W'($urandom_range(4095));
    else if ($urandom_range(2) == 0)
      it.aux2_pulse = PULSE_W'(near_value(int'(cfg_now.switch_on), 4095));
    else it.aux2_pulse = PULSE_W'($urandom_range(cfg_now.switch_on));
    if ($urandom_range(9) == 0) it.aux3_pulse = PULSE_W'($urandom_range(4095));
    else if ($urandom_range(4) == 0)
      it.aux3_pulse = PULSE_W'(near_value(int'(cfg_now.switch_on), 4095));
    else it.aux3_pulse = PULSE_W'($urandom_range(cfg_now.switch_on));
    it.gps_fix     = ($urandom_range(3) != 0);
    it.gps_healthy = ($urandom_range(3) != 0);
    if ($urandom_range(1) != 0)
      it.gps_satellites = SATS_W'(near_value(int'(cfg_now.min_sats), 63));
    else it.gps_satellites = SATS_W'($urandom_range(63));
    it.synth_valid = ($urandom_range(1) != 0);
    case ($urandom_range(9))
      0, 1, 2, 3: it.synth_confidence = CONF_W'(near_value(int'(cfg_now.conf_thr), 1023));
      4:          it.synth_confidence = CONF_W'($urandom_range(1023, 1001));
      default:    it.synth_confidence = CONF_W'($urandom_range(1000));
    endcase
    it.time_ms = $urandom;
    return it;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t               c;
    logic [PULSE_W-1:0] a;
    logic [PULSE_W-1:0] b;
    logic [PULSE_W-1:0] t;
    logic [PULSE_W-1:0] swap;
    if ($urandom_range(4) != 0) begin
      // Ordered band around the usual stick range
      a = PULSE_W'($urandom_range(2200, 800));
      b = PULSE_W'($urandom_range(2200, 800));
      t = PULSE_W'($urandom_range(2200, 800));
      if (a > b) begin swap = a; a = b; b = swap; end
      if (b > t) begin swap = b; b = t; t = swap; end
      if (a > b) begin swap = a; a = b; b = swap; end
      c.aux_low   = a;
      c.aux_mid   = b;
      c.aux_high  = t;
      c.switch_on = PULSE_W'($urandom_range(2300, 1200));
    end else begin
      c.aux_low   = PULSE_W'($urandom_range(4095));
      c.aux_mid   = PULSE_W'($urandom_range(4095));
      c.aux_high  = PULSE_W'($urandom_range(4095));
      c.switch_on = PULSE_W'($urandom_range(4095));
    end
    c.min_sats = ($urandom_range(3) == 0) ? SATS_W'($urandom_range(63))
                                          : SATS_W'($urandom_range(12));
    c.conf_thr = CONF_W'($urandom_range(1023));
    return c;
  endfunction

  // Offer one beat, idling first at the current sender rate; hold it until taken
  task automatic offer_beat(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_beat(it);
    s_tuser  <= it.req_type;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // Stop offering and wait until every predicted result has been retired
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    reg_write(REG_AUX_LOW, c.aux_low);
    reg_write(REG_AUX_MID, c.aux_mid);
    reg_write(REG_AUX_HIGH, c.aux_high);
    reg_write(REG_SW_ON, c.switch_on);
    reg_write(REG_MIN_SATS, CFG_DATA_W'(c.min_sats));
    reg_write(REG_CONF_THR, CFG_DATA_W'(c.conf_thr));
    reg_write(REG_SPARE_LO, CFG_DATA_W'($urandom_range(4095)));
    reg_write(REG_SPARE_HI, CFG_DATA_W'($urandom_range(4095)));
    cfg_we  <= 1'b0;
    cfg_now  = c;
    settings_loaded++;
  endtask

  initial begin
    cfg_t next_cfg;
    int   blk;
    int   n;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_UPDATE;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_AUX_LOW;
    cfg_wdata <= '0;
    rst       <= 1'b1;
    cfg_now    = '{aux_low: AUX_LOW_RST, aux_mid: AUX_MID_RST, aux_high: AUX_HIGH_RST,
                   switch_on: SW_ON_RST, min_sats: MIN_SATS_RST, conf_thr: CONF_THR_RST};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every mode, status and threshold edge at reset values
    offer_beat(mk_beat(REQ_UPDATE, 1500, 0, 0, 0, 1, 63, 0, 0, 32'd1));
    offer_beat(mk_beat(REQ_SWITCH, 0, 0, 0, 0, 0, 0, 0, 0, 32'd2));
    offer_beat(mk_beat(REQ_SWITCH, 1299, 0, 0, 0, 0, 0, 0, 0, 32'd3));
    offer_beat(mk_beat(REQ_SWITCH, 1300, 0, 0, 0, 0, 0, 0, 0, 32'd4));
    offer_beat(mk_beat(REQ_SWITCH, 1500, 0, 0, 0, 0, 0, 0, 0, 32'd5));
    // Position hold without any GPS source is refused
    offer_beat(mk_beat(REQ_SWITCH, 1700, 0, 0, 0, 1, 63, 1, 300, 32'd6));
    // Return refused while no home is latched, even with good GPS
    offer_beat(mk_beat(REQ_SWITCH, 4095, 1701, 0, 1, 1, 6, 0, 0, 32'd7));
    offer_beat(mk_beat(REQ_SWITCH, 1700, 0, 0, 0, 0, 0, 1, 301, 32'd8));
    // Lose both sources on an update: drop to altitude hold
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 0, 1, 0, 1, 300, 32'd9));
    offer_beat(mk_beat(REQ_SWITCH, 4095, 0, 0, 1, 1, 6, 0, 0, 32'd10));
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 1, 1, 5, 0, 0, 32'd11));
    // Home latches on the first good update only
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 1, 0, 63, 0, 0, 32'd12));
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 1, 1, 63, 0, 0, 32'd13));
    offer_beat(mk_beat(REQ_SWITCH, 0, 1701, 0, 1, 1, 6, 0, 0, 32'd14));
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 1, 1, 6, 0, 0, 32'd15));
    // Return without a fix falls back to stabilize
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 0, 1, 6, 1, 1000, 32'd16));
    // Headless needs no GPS and beats the return switch
    offer_beat(mk_beat(REQ_SWITCH, 0, 4095, 4095, 0, 0, 0, 0, 0, 32'd17));
    offer_beat(mk_beat(REQ_SWITCH, 0, 1700, 1700, 0, 0, 0, 0, 0, 32'd18));
    // Confidence beyond the per mille range still counts as plain unsigned
    offer_beat(mk_beat(REQ_SWITCH, 4095, 0, 0, 0, 0, 0, 1, 1023, 32'd19));
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 0, 0, 0, 1, 1023, 32'd20));
    offer_beat(mk_beat(REQ_SWITCH, 1499, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    // An unhealthy receiver is no GPS source for a switch
    offer_beat(mk_beat(REQ_SWITCH, 4095, 4095, 0, 1, 0, 63, 0, 0, 32'd22));
    offer_beat(mk_beat(REQ_SWITCH, 4095, 4095, 0, 1, 1, 63, 0, 0, 32'd23));
    offer_beat(mk_beat(REQ_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 32'd24));
    offer_beat(mk_beat(REQ_SWITCH, 1699, 0, 0, 0, 0, 0, 0, 0, 32'd25));

    // Random blocks, each under its own register settings; idle rates move from
    // a lazy receiver to a lazy sender to none at all
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      wait_all_results();
      case (blk)
        0: next_cfg = '{aux_low: AUX_LOW_RST, aux_mid: AUX_MID_RST, aux_high: AUX_HIGH_RST,
                        switch_on: SW_ON_RST, min_sats: MIN_SATS_RST, conf_thr: CONF_THR_RST};
        2: next_cfg = '{aux_low: '0, aux_mid: '0, aux_high: '0, switch_on: '0,
                        min_sats: '0, conf_thr: '0};
        3: next_cfg = '{aux_low: '1, aux_mid: '1, aux_high: '1, switch_on: '1,
                        min_sats: '1, conf_thr: '1};
        default: next_cfg = random_cfg();
      endcase
      load_settings(next_cfg);
      case (blk / 2)
        0:       begin send_idle_pct = 10; recv_idle_pct = 62; end
        1:       begin send_idle_pct = 62; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (n = 0; n < BEATS_PER_BLOCK; n++) begin
        // Hold off the result side while beats keep coming, so the block backs up
        if (blk == 4 && n == 40) hold_request = 80;
        // Pause the sender until the pipeline has drained completely
        if (blk == 5 && n == 80) wait_all_results();
        offer_beat(random_beat());
      end
    end

    wait_all_results();
    repeat (5) @(posedge clk);

    $display("Covered %0d beats under %0d register settings, %0d results checked.",
             beats_sent, settings_loaded + 1, checked);
    $display("Status codes returned (bit per code, lowest is none): %b", status_seen);
    if (failures == 0 && outstanding == 0) begin
      $display("flight_mode_supervisor regression: pass");
    end else begin
      $display("flight_mode_supervisor regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fms_pkg.sv
rtl/fms_cfg_regs.sv
rtl/fms_mode_core.sv
rtl/flight_mode_supervisor.sv
dv/fms_checker.sv
dv/tb_top.sv
